FILE: sv/metaphone_key_encoder_top_macros.svh
// Assertion macros for the key encoder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef METAPHONE_KEY_ENCODER_TOP_MACROS_SVH
`define METAPHONE_KEY_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MKE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MKE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/mke_pkg.sv
package mke_pkg;

  // Key sizing
  localparam int KEY_LIMIT       = 6;
  localparam int KEY_DEPTH       = 7;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_word;
  } byte_t;

  // Result beat
  typedef struct packed {
    logic [7:0] key_char_0;
    logic [7:0] key_char_1;
    logic [7:0] key_char_2;
    logic [7:0] key_char_3;
    logic [7:0] key_char_4;
    logic [7:0] key_char_5;
    logic [7:0] key_char_6;
    logic [2:0] key_length;
  } key_t;

  // Classified item between front and back; code 0 means no letter
  typedef struct packed {
    logic [4:0] code;
    logic       eow;
  } item_t;

  // Back-end status
  typedef struct packed {
    logic       flushing;
    logic       final_step;
    logic [2:0] key_count;
  } bk_stat_t;

  // Letter codes: 0 is null, 1..26 are A..Z
  localparam logic [4:0] LC_NULL = 5'd0;
  localparam logic [4:0] LC_A = 5'd1;
  localparam logic [4:0] LC_B = 5'd2;
  localparam logic [4:0] LC_C = 5'd3;
  localparam logic [4:0] LC_D = 5'd4;
  localparam logic [4:0] LC_E = 5'd5;
  localparam logic [4:0] LC_G = 5'd7;
  localparam logic [4:0] LC_H = 5'd8;
  localparam logic [4:0] LC_I = 5'd9;
  localparam logic [4:0] LC_K = 5'd11;
  localparam logic [4:0] LC_M = 5'd13;
  localparam logic [4:0] LC_N = 5'd14;
  localparam logic [4:0] LC_O = 5'd15;
  localparam logic [4:0] LC_P = 5'd16;
  localparam logic [4:0] LC_Q = 5'd17;
  localparam logic [4:0] LC_R = 5'd18;
  localparam logic [4:0] LC_S = 5'd19;
  localparam logic [4:0] LC_T = 5'd20;
  localparam logic [4:0] LC_V = 5'd22;
  localparam logic [4:0] LC_W = 5'd23;
  localparam logic [4:0] LC_X = 5'd24;
  localparam logic [4:0] LC_Y = 5'd25;
  localparam logic [4:0] LC_Z = 5'd26;

  // ASCII values
  localparam logic [7:0] CH_BASE   = 8'h40;  // code + base = letter
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_J    = 8'h4A;
  localparam logic [7:0] CH_K    = 8'h4B;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Letter class bits
  localparam logic [4:0] CLS_VOWEL  = 5'b00001;
  localparam logic [4:0] CLS_SAME   = 5'b00010;
  localparam logic [4:0] CLS_VARSON = 5'b00100;
  localparam logic [4:0] CLS_FRONTV = 5'b01000;
  localparam logic [4:0] CLS_NOGHF  = 5'b10000;

  // Five-class letter table
  function automatic logic [4:0] letter_class(input logic [4:0] code);
    logic [4:0] cls;
    case (code)
      5'd1:    cls = 5'd1;
      5'd2:    cls = 5'd16;
      5'd3:    cls = 5'd4;
      5'd4:    cls = 5'd16;
      5'd5:    cls = 5'd9;
      5'd6:    cls = 5'd2;
      5'd7:    cls = 5'd4;
      5'd8:    cls = 5'd16;
      5'd9:    cls = 5'd9;
      5'd10:   cls = 5'd2;
      5'd12:   cls = 5'd2;
      5'd13:   cls = 5'd2;
      5'd14:   cls = 5'd2;
      5'd15:   cls = 5'd1;
      5'd16:   cls = 5'd4;
      5'd18:   cls = 5'd2;
      5'd19:   cls = 5'd4;
      5'd20:   cls = 5'd4;
      5'd21:   cls = 5'd1;
      5'd25:   cls = 5'd8;
      default: cls = 5'd0;
    endcase
    return cls;
  endfunction

endpackage

FILE: sv/mke_front.sv
module mke_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  mke_pkg::byte_t byte_data,
  output logic          f_valid,
  input  logic          f_stall,
  output mke_pkg::item_t f_item
);
  import mke_pkg::*;

  logic [7:0] upper;
  logic       is_letter;
  logic       keep;
  logic       accept;

  // Case fold and letter detect
  always_comb begin
    upper = byte_data.char_byte;
    if (byte_data.char_byte >= CH_LOWER_A && byte_data.char_byte <= CH_LOWER_Z) begin
      upper = byte_data.char_byte - CASE_OFFSET;
    end
    is_letter = (upper >= CH_UPPER_A) && (upper <= CH_UPPER_Z);
    keep      = is_letter || byte_data.end_of_word;
  end

  assign byte_stall = f_valid && f_stall;
  assign accept     = byte_valid && !byte_stall;

  // Classified beat register; bytes that are neither letters nor word ends are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= keep;
    end else if (!f_stall) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item.code <= is_letter ? 5'(upper - CH_BASE) : LC_NULL;
      f_item.eow  <= byte_data.end_of_word;
    end
  end

endmodule

FILE: sv/mke_queue.sv
module mke_queue #(
  parameter int DEPTH = mke_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mke_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_stall,
  output mke_pkg::item_t out_item
);
  import mke_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_stall  = (count == CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/mke_back.sv
module mke_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_stall,
  input  mke_pkg::item_t    q_item,
  output logic             key_valid,
  input  logic             key_stall,
  output mke_pkg::key_t     key_data,
  output mke_pkg::bk_stat_t stat
);
  import mke_pkg::*;

  logic [4:0] win [8];
  logic [4:0] sh  [8];
  logic [7:0] key_store [KEY_DEPTH];
  logic [7:0] ks_next   [KEY_DEPTH];
  logic [2:0] key_count;
  logic [2:0] kc_next;
  logic [2:0] seen;
  logic [1:0] flush_cnt;

  logic       busy;
  logic       last;
  logic       out_free;
  logic       flush_go;
  logic       load;
  logic       adv;
  logic       pop;
  logic [4:0] adv_code;

  logic [4:0] c, p1, n1, n2, n3;
  logic [7:0] ascii;
  logic [1:0] n_put;
  logic [7:0] ch0, ch1;
  logic [2:0] idx1;

  function automatic logic vowel(input logic [4:0] x);
    return |(letter_class(x) & CLS_VOWEL);
  endfunction

  function automatic logic same(input logic [4:0] x);
    return |(letter_class(x) & CLS_SAME);
  endfunction

  function automatic logic varson(input logic [4:0] x);
    return |(letter_class(x) & CLS_VARSON);
  endfunction

  function automatic logic frontv(input logic [4:0] x);
    return |(letter_class(x) & CLS_FRONTV);
  endfunction

  function automatic logic noghf(input logic [4:0] x);
    return |(letter_class(x) & CLS_NOGHF);
  endfunction

  // Step control: a word end costs three extra steps for the pending letters
  assign busy     = (flush_cnt != 2'd0);
  assign last     = (flush_cnt == 2'd1);
  assign out_free = !key_valid || !key_stall;
  assign flush_go = !last || out_free;
  assign load     = busy && last && flush_go;
  assign pop      = !busy && q_valid;
  assign q_stall  = busy;
  assign adv      = busy ? flush_go : (q_valid && (q_item.code != LC_NULL));
  assign adv_code = busy ? LC_NULL : q_item.code;

  // Window shift plus start rules on the first letter of the word
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      sh[i] = win[i+1];
    end
    sh[7] = adv_code;
    if (seen == 3'd3) begin
      case (sh[4])
        LC_P, LC_K, LC_G: begin
          if (sh[5] == LC_N) sh[4] = LC_NULL;
        end
        LC_A: begin
          if (sh[5] == LC_E) sh[4] = LC_NULL;
        end
        LC_W: begin
          if (sh[5] == LC_R) begin
            sh[4] = LC_NULL;
          end else if (sh[5] == LC_H) begin
            sh[5] = sh[4];
            sh[4] = LC_NULL;
          end
        end
        LC_X: begin
          sh[4] = LC_S;
        end
        default: ;
      endcase
    end
  end

  // Letter coding for the current position
  always_comb begin
    c     = sh[4];
    p1    = sh[3];
    n1    = sh[5];
    n2    = sh[6];
    n3    = sh[7];
    ascii = CH_BASE + {3'b000, c};
    n_put = 2'd0;
    ch0   = '0;
    ch1   = '0;
    if (c != LC_NULL && key_count < 3'(KEY_LIMIT) && !(p1 == c && c != LC_C)) begin
      if (same(c) || (p1 == LC_NULL && vowel(c))) begin
        n_put = 2'd1;
        ch0   = ascii;
      end else begin
        case (c)
          LC_B: begin
            if (n1 != LC_NULL || p1 != LC_M) begin
              n_put = 2'd1;
              ch0   = CH_B;
            end
          end
          LC_C: begin
            if (p1 != LC_S || !frontv(n1)) begin
              n_put = 2'd1;
              if (n1 == LC_I && n2 == LC_A) begin
                ch0 = CH_X;
              end else if (frontv(n1)) begin
                ch0 = CH_S;
              end else if (n1 == LC_H) begin
                ch0 = ((p1 == LC_NULL && !vowel(n2)) || p1 == LC_S) ? CH_K : CH_X;
              end else begin
                ch0 = CH_K;
              end
            end
          end
          LC_D: begin
            n_put = 2'd1;
            ch0   = (n1 == LC_G && frontv(n2)) ? CH_J : CH_T;
          end
          LC_G: begin
            if ((n1 != LC_G || vowel(n2)) &&
                (n1 != LC_N || (n2 != LC_NULL && (n2 != LC_E || n3 != LC_D))) &&
                (p1 != LC_D || !frontv(n1))) begin
              n_put = 2'd1;
              ch0   = (frontv(n1) && n2 != LC_G) ? CH_J : CH_K;
            end else if (n1 == LC_H && !noghf(sh[1]) && sh[0] != LC_H) begin
              n_put = 2'd1;
              ch0   = CH_F;
            end
          end
          LC_H: begin
            if (!varson(p1) && (!vowel(p1) || vowel(n1))) begin
              n_put = 2'd1;
              ch0   = CH_H;
            end
          end
          LC_K: begin
            if (p1 != LC_C) begin
              n_put = 2'd1;
              ch0   = CH_K;
            end
          end
          LC_P: begin
            n_put = 2'd1;
            ch0   = (n1 == LC_H) ? CH_F : CH_P;
          end
          LC_Q: begin
            n_put = 2'd1;
            ch0   = CH_K;
          end
          LC_S: begin
            n_put = 2'd1;
            ch0   = (n1 == LC_H || (n1 == LC_I && (n2 == LC_O || n2 == LC_A))) ? CH_X : CH_S;
          end
          LC_T: begin
            if (n1 == LC_I && (n2 == LC_O || n2 == LC_A)) begin
              n_put = 2'd1;
              ch0   = CH_X;
            end else if (n1 == LC_H) begin
              n_put = 2'd1;
              ch0   = CH_ZERO;
            end else if (n1 != LC_C || n2 != LC_H) begin
              n_put = 2'd1;
              ch0   = CH_T;
            end
          end
          LC_V: begin
            n_put = 2'd1;
            ch0   = CH_F;
          end
          LC_W, LC_Y: begin
            if (vowel(n1)) begin
              n_put = 2'd1;
              ch0   = ascii;
            end
          end
          LC_X: begin
            if (p1 == LC_NULL) begin
              n_put = 2'd1;
              ch0   = CH_S;
            end else begin
              n_put = 2'd2;
              ch0   = CH_K;
              ch1   = CH_S;
            end
          end
          LC_Z: begin
            n_put = 2'd1;
            ch0   = CH_S;
          end
          default: ;
        endcase
      end
    end
  end

  // Key append
  assign idx1    = key_count + 3'd1;
  assign kc_next = key_count + {1'b0, n_put};

  always_comb begin
    ks_next = key_store;
    if (n_put != 2'd0) ks_next[key_count] = ch0;
    if (n_put == 2'd2) ks_next[idx1] = ch1;
  end

  // Word state
  always_ff @(posedge clk) begin
    if (rst || load) begin
      win       <= '{default: '0};
      key_store <= '{default: '0};
      key_count <= '0;
      seen      <= '0;
      flush_cnt <= '0;
    end else begin
      if (adv) begin
        win       <= sh;
        key_store <= ks_next;
        key_count <= kc_next;
        if (seen < 3'd4) seen <= seen + 3'd1;
      end
      if (busy && flush_go) begin
        flush_cnt <= flush_cnt - 2'd1;
      end else if (pop && q_item.eow) begin
        flush_cnt <= 2'd3;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      key_valid <= load || (key_valid && key_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_data.key_char_0 <= ks_next[0];
      key_data.key_char_1 <= ks_next[1];
      key_data.key_char_2 <= ks_next[2];
      key_data.key_char_3 <= ks_next[3];
      key_data.key_char_4 <= ks_next[4];
      key_data.key_char_5 <= ks_next[5];
      key_data.key_char_6 <= ks_next[6];
      key_data.key_length <= kc_next;
    end
  end

  assign stat.flushing   = busy;
  assign stat.final_step = load;
  assign stat.key_count  = key_count;

endmodule

FILE: sv/metaphone_key_encoder_top.sv
// Phonetic key encoder. Bytes of a word enter on the byte channel
// (byte_valid / byte_stall / byte_data), one beat per byte; the beat with
// end_of_word set closes the word. Non-letters are dropped, case is folded.
// One key beat per word leaves on the key channel (key_valid / key_stall /
// key_data): seven ASCII characters, zero past key_length.
// Throughput: the front end takes one byte per cycle when byte_stall is
// low. The back end takes one queue entry per step, letter or word end,
// and spends three more steps per word end to move the pending letters
// through the window. The queue of QUEUE_DEPTH entries rides out one word
// end, but a steady stream of words fills it and byte_stall holds the rest.
// With the queue and back end idle, the end-of-word beat passes the front
// register, the queue write, one back step and three flush steps; the last
// flush step loads the output register that holds the key beat.
// Reset (rst, synchronous) empties the front register, the queue and the
// output register and clears the window and key.
// When key_stall is held the finished key waits in its output register; the
// back end keeps working on the next word until it needs that register, the
// queue then fills and byte_stall rises.
module metaphone_key_encoder_top #(
  parameter int QUEUE_DEPTH = mke_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  mke_pkg::byte_t byte_data,
  output logic          key_valid,
  input  logic          key_stall,
  output mke_pkg::key_t  key_data
);
  import mke_pkg::*;

  `include "metaphone_key_encoder_top_macros.svh"

  logic     f_valid;
  logic     f_stall;
  item_t    f_item;
  logic     q_valid;
  logic     q_stall;
  item_t    q_item;
  bk_stat_t bk_stat;

  mke_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .f_valid    (f_valid),
    .f_stall    (f_stall),
    .f_item     (f_item)
  );

  mke_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_stall  (f_stall),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_item  (q_item)
  );

  mke_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_item    (q_item),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_data  (key_data),
    .stat      (bk_stat)
  );

  // A new key beat only appears after the last flush step
  `MKE_ASSERT_IMPLY(a_key_after_flush, $rose(key_valid), $past(bk_stat.final_step), "key beat without flush")
  // The back end takes no queue entry while flushing a word
  `MKE_ASSERT_IMPLY(a_no_pop_in_flush, bk_stat.flushing, q_stall, "queue popped during flush")
  // The final step clears the key for the next word
  `MKE_ASSERT_NEXT(a_key_cleared, bk_stat.final_step, bk_stat.key_count == 3'd0, "key not cleared")

endmodule

FILE: sim/metaphone_key_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the key encoder, predicts the key of every word
// and compares each key beat with the oldest prediction.
module metaphone_key_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic           byte_stall,
  input  mke_pkg::byte_t byte_data,
  input  logic           key_valid,
  input  logic           key_stall,
  input  mke_pkg::key_t  key_data,
  output int             mismatch_count,
  output int             keys_due
);
  import mke_pkg::*;

  // Letter codes the package does not name
  localparam logic [4:0] CODE_F = 5'd6;
  localparam logic [4:0] CODE_J = 5'd10;
  localparam logic [4:0] CODE_L = 5'd12;
  localparam logic [4:0] CODE_U = 5'd21;

  // Predictor state: window of letter codes, key built so far
  logic [4:0] window [8];
  logic [7:0] key_chars [KEY_DEPTH];
  int         key_len;
  int         letters_in;

  key_t predicted_keys [$];

  // Letter classes
  function automatic bit is_vowel(input logic [4:0] c);
    return c == LC_A || c == LC_E || c == LC_I || c == LC_O || c == CODE_U;
  endfunction

  function automatic bit codes_as_self(input logic [4:0] c);
    return c == CODE_F || c == CODE_J || c == CODE_L || c == LC_M || c == LC_N
        || c == LC_R;
  endfunction

  function automatic bit softens_h(input logic [4:0] c);
    return c == LC_C || c == LC_G || c == LC_P || c == LC_S || c == LC_T;
  endfunction

  function automatic bit is_front_vowel(input logic [4:0] c);
    return c == LC_E || c == LC_I || c == LC_Y;
  endfunction

  function automatic bit blocks_gh_f(input logic [4:0] c);
    return c == LC_B || c == LC_D || c == LC_H;
  endfunction

  task automatic clear_word();
    for (int i = 0; i < 8; i++) window[i] = LC_NULL;
    for (int i = 0; i < KEY_DEPTH; i++) key_chars[i] = 8'd0;
    key_len    = 0;
    letters_in = 0;
  endtask

  task automatic append_key(input logic [7:0] ch);
    if (key_len < KEY_DEPTH) begin
      key_chars[key_len] = ch;
      key_len++;
    end
  endtask

  // Word-start rules on the first letter, once it reaches the current slot
  task automatic apply_start_rules();
    logic [4:0] c;
    c = window[4];
    if (c == LC_P || c == LC_K || c == LC_G) begin
      if (window[5] == LC_N) window[4] = LC_NULL;
    end else if (c == LC_A) begin
      if (window[5] == LC_E) window[4] = LC_NULL;
    end else if (c == LC_W) begin
      if (window[5] == LC_R) begin
        window[4] = LC_NULL;
      end else if (window[5] == LC_H) begin
        window[5] = window[4];
        window[4] = LC_NULL;
      end
    end else if (c == LC_X) begin
      window[4] = LC_S;
    end
  endtask

  // Letter rules for the current slot
  task automatic code_current();
    logic [4:0] c, p1, n1, n2, n3;
    c  = window[4];
    p1 = window[3];
    n1 = window[5];
    n2 = window[6];
    n3 = window[7];
    if (c == LC_NULL || key_len >= KEY_LIMIT) return;
    if (p1 == c && c != LC_C) return;
    if (codes_as_self(c) || (p1 == LC_NULL && is_vowel(c))) begin
      append_key(CH_BASE + 8'(c));
      return;
    end
    case (c)
      LC_B: begin
        if (n1 != LC_NULL || p1 != LC_M) append_key(CH_B);
      end
      LC_C: begin
        if (p1 != LC_S || !is_front_vowel(n1)) begin
          if (n1 == LC_I && n2 == LC_A) append_key(CH_X);
          else if (is_front_vowel(n1)) append_key(CH_S);
          else if (n1 == LC_H)
            append_key(((p1 == LC_NULL && !is_vowel(n2)) || p1 == LC_S) ? CH_K : CH_X);
          else append_key(CH_K);
        end
      end
      LC_D: begin
        append_key((n1 == LC_G && is_front_vowel(n2)) ? CH_J : CH_T);
      end
      LC_G: begin
        if ((n1 != LC_G || is_vowel(n2)) &&
            (n1 != LC_N || (n2 != LC_NULL && (n2 != LC_E || n3 != LC_D))) &&
            (p1 != LC_D || !is_front_vowel(n1))) begin
          append_key((is_front_vowel(n1) && n2 != LC_G) ? CH_J : CH_K);
        end else if (n1 == LC_H && !blocks_gh_f(window[1]) && window[0] != LC_H) begin
          append_key(CH_F);
        end
      end
      LC_H: begin
        if (!softens_h(p1) && (!is_vowel(p1) || is_vowel(n1))) append_key(CH_H);
      end
      LC_K: begin
        if (p1 != LC_C) append_key(CH_K);
      end
      LC_P: append_key(n1 == LC_H ? CH_F : CH_P);
      LC_Q: append_key(CH_K);
      LC_S: begin
        append_key((n1 == LC_H || (n1 == LC_I && (n2 == LC_O || n2 == LC_A)))
                   ? CH_X : CH_S);
      end
      LC_T: begin
        if (n1 == LC_I && (n2 == LC_O || n2 == LC_A)) append_key(CH_X);
        else if (n1 == LC_H) append_key(CH_ZERO);
        else if (n1 != LC_C || n2 != LC_H) append_key(CH_T);
      end
      LC_V: append_key(CH_F);
      LC_W, LC_Y: begin
        if (is_vowel(n1)) append_key(CH_BASE + 8'(c));
      end
      LC_X: begin
        if (p1 == LC_NULL) begin
          append_key(CH_S);
        end else begin
          append_key(CH_K);
          append_key(CH_S);
        end
      end
      LC_Z: append_key(CH_S);
      default: ;
    endcase
  endtask

  task automatic shift_letter(input logic [4:0] code);
    int prev;
    prev = letters_in;
    for (int i = 0; i < 7; i++) window[i] = window[i + 1];
    window[7] = code;
    if (prev < 4) letters_in = prev + 1;
    if (prev == 3) apply_start_rules();
    code_current();
  endtask

  // One accepted byte beat; the end of a word flushes and queues its key
  task automatic encode_byte(input byte_t b);
    logic [7:0] ch;
    key_t       k;
    ch = b.char_byte;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_OFFSET;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) shift_letter(5'(ch - CH_BASE));
    if (!b.end_of_word) return;
    for (int i = 0; i < 3; i++) shift_letter(LC_NULL);
    k.key_char_0 = key_chars[0];
    k.key_char_1 = key_chars[1];
    k.key_char_2 = key_chars[2];
    k.key_char_3 = key_chars[3];
    k.key_char_4 = key_chars[4];
    k.key_char_5 = key_chars[5];
    k.key_char_6 = key_chars[6];
    k.key_length = 3'(key_len);
    predicted_keys.push_back(k);
    clear_word();
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Sample both channels at each edge
  always @(posedge clk) begin
    key_t want;
    if (rst) begin
      clear_word();
      predicted_keys.delete();
    end else begin
      if (key_valid && !key_stall) begin
        if (predicted_keys.size() == 0) begin
          $display("%0t: key beat with none expected, expected none, got %h",
                   $time, key_data);
          mismatch_count++;
        end else begin
          want = predicted_keys.pop_front();
          check_field("key_char_0", want.key_char_0, key_data.key_char_0);
          check_field("key_char_1", want.key_char_1, key_data.key_char_1);
          check_field("key_char_2", want.key_char_2, key_data.key_char_2);
          check_field("key_char_3", want.key_char_3, key_data.key_char_3);
          check_field("key_char_4", want.key_char_4, key_data.key_char_4);
          check_field("key_char_5", want.key_char_5, key_data.key_char_5);
          check_field("key_char_6", want.key_char_6, key_data.key_char_6);
          check_field("key_length", 8'(want.key_length), 8'(key_data.key_length));
        end
      end
      if (byte_valid && !byte_stall) encode_byte(byte_data);
    end
    keys_due <= predicted_keys.size();
  end

endmodule

FILE: sim/tb_metaphone_key_encoder_top.sv
`timescale 1ns / 100ps

module tb_metaphone_key_encoder_top;
  import mke_pkg::*;

  localparam int BYTE_TARGET  = 1550;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD_AT = 60;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_PAUSE  = 20;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  byte_valid = 1'b0;
  logic  byte_stall;
  byte_t byte_data  = '0;
  logic  key_valid;
  logic  key_stall  = 1'b0;
  key_t  key_data;

  int mismatch_count;
  int keys_due;
  int cycle_count = 0;
  int beats_sent  = 0;
  int keys_taken  = 0;
  bit calm_sender = 1'b0;

  // Spelling patterns that reach the special rules
  string word_parts [40] = '{
    "PN", "KN", "GN", "AE", "WR", "WH", "X", "GH", "GHT", "SCH",
    "CIA", "CE", "CI", "CY", "CH", "TIO", "TIA", "TH", "TCH", "DGE",
    "GNED", "GG", "MB", "CK", "PH", "SIO", "SIA", "SH", "Q", "V",
    "W", "Y", "Z", "A", "E", "I", "O", "U", "SC", "NED"
  };

  always #4 clk = ~clk;

  metaphone_key_encoder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_data  (byte_data),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_data   (key_data)
  );

  metaphone_key_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .byte_data      (byte_data),
    .key_valid      (key_valid),
    .key_stall      (key_stall),
    .key_data       (key_data),
    .mismatch_count (mismatch_count),
    .keys_due       (keys_due)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic bit is_letter(input logic [7:0] ch);
    return (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) || (ch >= CH_LOWER_A && ch <= CH_LOWER_Z);
  endfunction

  function automatic logic [7:0] any_non_letter();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (is_letter(b)) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] random_case(input logic [7:0] ch);
    if (is_letter(ch) && $urandom_range(0, 1) == 1) return ch | CASE_OFFSET;
    return ch;
  endfunction

  // One byte beat, after a random gap; valid stays up across back-to-back beats
  task automatic push_byte(input logic [7:0] ch, input logic eow);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data  <= '{char_byte: ch, end_of_word: eow};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_bytes(input logic [7:0] word_bytes [$]);
    foreach (word_bytes[i]) push_byte(word_bytes[i], i == word_bytes.size() - 1);
  endtask

  // Hold the byte side until every key has come back
  task automatic wait_keys_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (keys_due != 0) @(posedge clk);
  endtask

  // Key side: random stalls, calm stretches, and one long hold-off
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      if (keys_taken == LONG_HOLD_AT) hold = LONG_HOLD;
      else if ((keys_taken / 40) % 4 == 2) hold = 0;
      else hold = $urandom_range(0, 8);
      if (hold > 0) begin
        key_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      key_stall <= 1'b0;
      @(posedge clk);
      while (!key_valid) @(posedge clk);
      keys_taken++;
    end
  end

  // Byte side: reset, directed words, random words, drain, verdict
  initial begin
    logic [7:0] word_bytes [$];
    string      part;
    int         kind, word_idx, n;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty words at byte extremes, GN before end and before ED,
    // key limit with X, ignored byte inside a WH start, PN start, X start
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    send_text("AGN");
    send_text("AGNED");
    send_text("bFlMnx");
    push_byte("w", 1'b0);
    push_byte("?", 1'b0);
    push_byte("H", 1'b0);
    push_byte("o", 1'b1);
    send_text("Pn");
    send_text("XRAY");
    wait_keys_drained();

    // Random words
    word_idx = 0;
    while (beats_sent < BYTE_TARGET) begin
      calm_sender = ((word_idx / 40) % 4 == 3);
      if (word_idx == 120) wait_keys_drained();
      word_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        // well-formed word from rule-heavy fragments, mixed case, some noise
        n = $urandom_range(1, 5);
        for (int f = 0; f < n; f++) begin
          if ($urandom_range(0, 9) < 3) part = "";
          else part = word_parts[$urandom_range(0, $size(word_parts) - 1)];
          if (part.len() == 0) begin
            if ($urandom_range(0, 9) == 0) word_bytes.push_back(any_non_letter());
            word_bytes.push_back(random_case(CH_UPPER_A + 8'($urandom_range(0, 25))));
          end else begin
            for (int i = 0; i < part.len(); i++) begin
              if ($urandom_range(0, 9) == 0) word_bytes.push_back(any_non_letter());
              word_bytes.push_back(random_case(part[i]));
            end
          end
        end
      end else if (kind < 90) begin
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
          word_bytes.push_back(random_case(CH_UPPER_A + 8'($urandom_range(0, 25))));
      end else if (kind < 97) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) word_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        word_bytes.push_back(any_non_letter());
      end
      send_bytes(word_bytes);
      word_idx++;
    end

    wait_keys_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
